// File: rtl/cogp_pkg.sv
// Shared types, constants and the pipeline step function for the circle outline/gradient pixel block.
`default_nettype none
package cogp_pkg;

	localparam int unsigned NSTG = 12;
	localparam logic [3:0] THICK_RST = 4'd3;
	localparam logic [7:0] ALPHA_MAX = 8'd255;

	typedef struct packed {
		logic [13:0] px;
		logic [13:0] py;
		logic        outline;
		logic        fill;
		logic        r_zero;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  rad;
		logic [18:0] sq_a;
		logic [18:0] sq_b;
		logic [15:0] r2;
		logic [16:0] outer;
		logic [16:0] v;
		logic [16:0] root;
		logic [8:0]  rem;
		logic [7:0]  numr;
		logic [7:0]  q;
		logic [7:0]  alpha;
	} pl_t;

	// stage k work on the item held by stage k-1 (k >= 2)
	function automatic pl_t stage_step(input int unsigned k, input pl_t p);
		pl_t n;
		logic [19:0] d2;
		logic [16:0] bit_v;
		logic [16:0] trial;
		logic [15:0] num;
		int unsigned j;
		n = p;
		d2 = '0;
		bit_v = '0;
		trial = '0;
		num = '0;
		j = 0;
		if (k == 2) begin
			d2 = {1'b0, p.sq_a} + {1'b0, p.sq_b};
			n.outline = (d2 >= {4'b0, p.r2}) && (d2 <= {3'b0, p.outer});
			n.fill = (d2 <= {4'b0, p.r2});
			n.v = {1'b0, d2[15:0]};
			n.root = '0;
		end else if (k >= 3 && k <= 6) begin
			// integer square root, two digits per stage
			for (int i = 0; i < 2; i++) begin
				j = 2 * (k - 3) + i;
				bit_v = 17'(1) << (14 - 2 * j);
				trial = n.root + bit_v;
				if (n.v >= trial) begin
					n.v = n.v - trial;
					n.root = (n.root >> 1) + bit_v;
				end else begin
					n.root = n.root >> 1;
				end
			end
		end else if (k == 7) begin
			num = {n.root[7:0], 8'b0} - {8'b0, n.root[7:0]};
			n.rem = {1'b0, num[15:8]};
			n.numr = num[7:0];
			n.q = '0;
		end else if (k >= 8 && k <= 11) begin
			// restoring divide by radius, two quotient bits per stage
			for (int i = 0; i < 2; i++) begin
				n.rem = {n.rem[7:0], n.numr[7]};
				n.numr = {n.numr[6:0], 1'b0};
				if (n.rem >= {1'b0, n.rad}) begin
					n.rem = n.rem - {1'b0, n.rad};
					n.q = {n.q[6:0], 1'b1};
				end else begin
					n.q = {n.q[6:0], 1'b0};
				end
			end
		end else if (k == 12) begin
			if (!p.fill)
				n.alpha = '0;
			else if (p.r_zero)
				n.alpha = ALPHA_MAX;
			else
				n.alpha = ALPHA_MAX - p.q;
		end
		return n;
	endfunction

endpackage
`default_nettype wire

// File: rtl/circle_outline_gradient_pixel.sv
// Top level: pipelined disc outline / fill classifier with radial alpha.
// Throughput: one request per cycle unless m_tready back-pressure fills the stages;
// sqrt and divide take two digits per stage.
// Each stage loads when empty or when the stage after it moves, so bubbles close up.
// Reset (arst_n low, async): all stage valid bits clear, thickness returns to 3.
`default_nettype none
module circle_outline_gradient_pixel (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [3:0]  cfg_wdata,     // outline_thickness
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// offset_x[9:0], offset_y[19:10], center_x[31:20], center_y[43:32],
	// radius[51:44], red[59:52], green[67:60], blue[75:68], zero[79:76]
	input  wire logic [79:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// pixel_x[13:0], pixel_y[27:14], draw_outline[28], draw_fill[29],
	// fill_red[37:30], fill_green[45:38], fill_blue[53:46], fill_alpha[61:54], zero[63:62]
	output logic [63:0]      m_tdata
);

	logic [3:0] thick_q;
	cogp_pkg::pl_t st_s  [1:cogp_pkg::NSTG];
	cogp_pkg::pl_t nxt   [1:cogp_pkg::NSTG];
	logic [cogp_pkg::NSTG:1]   vld_s;
	logic [cogp_pkg::NSTG+1:1] rdy;

	logic signed [9:0]  dx, dy;
	logic signed [19:0] dxx, dyy;
	logic [8:0]         rs;
	logic [17:0]        rs2;
	logic [15:0]        rr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thick_q <= cogp_pkg::THICK_RST;
		else if (cfg_wen)
			thick_q <= cfg_wdata;
	end

	always_comb begin
		dx = s_tdata[9:0];
		dy = s_tdata[19:10];
		dxx = dx * dx;
		dyy = dy * dy;
		rs = {1'b0, s_tdata[51:44]} + {5'b0, thick_q};
		rs2 = rs * rs;
		rr = s_tdata[51:44] * s_tdata[51:44];
		nxt[1] = '0;
		nxt[1].px = {2'b0, s_tdata[31:20]} + {{4{dx[9]}}, dx};
		nxt[1].py = {2'b0, s_tdata[43:32]} + {{4{dy[9]}}, dy};
		nxt[1].rad = s_tdata[51:44];
		nxt[1].r_zero = (s_tdata[51:44] == 8'd0);
		nxt[1].red = s_tdata[59:52];
		nxt[1].green = s_tdata[67:60];
		nxt[1].blue = s_tdata[75:68];
		nxt[1].sq_a = dxx[18:0];
		nxt[1].sq_b = dyy[18:0];
		nxt[1].r2 = rr;
		nxt[1].outer = rs2[16:0];
		for (int unsigned k = 2; k <= cogp_pkg::NSTG; k++)
			nxt[k] = cogp_pkg::stage_step(k, st_s[k-1]);
	end

	always_comb begin
		rdy[cogp_pkg::NSTG+1] = m_tready;
		for (int k = cogp_pkg::NSTG; k >= 1; k--)
			rdy[k] = !vld_s[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[1])
				vld_s[1] <= s_tvalid;
			for (int k = 2; k <= cogp_pkg::NSTG; k++)
				if (rdy[k])
					vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= cogp_pkg::NSTG; k++)
			if (rdy[k])
				st_s[k] <= nxt[k];
	end

	assign s_tready = rdy[1];
	assign m_tvalid = vld_s[cogp_pkg::NSTG];
	assign m_tdata = {2'b0,
		st_s[cogp_pkg::NSTG].alpha,
		st_s[cogp_pkg::NSTG].blue,
		st_s[cogp_pkg::NSTG].green,
		st_s[cogp_pkg::NSTG].red,
		st_s[cogp_pkg::NSTG].fill,
		st_s[cogp_pkg::NSTG].outline,
		st_s[cogp_pkg::NSTG].py,
		st_s[cogp_pkg::NSTG].px};

endmodule
`default_nettype wire

// File: rtl/cogp_checker.sv
// Port-level assertions for the circle outline/gradient pixel block, with its bind.
`default_nettype none
module cogp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata
);

	// stalled result request holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result request changed while stalled");

	// no fill means zero alpha
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[29] |-> m_tdata[61:54] == 8'd0)
		else $error("alpha set outside the disc");

	// a moving output frees the input side
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

	// empty output stage never blocks input
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind circle_outline_gradient_pixel cogp_checker u_cogp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// File: sim/circle_pixel_monitor.sv
// Request/result monitor for the disc pixel classifier: predicts every result and compares it.
module circle_pixel_monitor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [3:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [79:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [63:0] m_tdata,
	output int               in_flight,
	output int               mismatches
);
	// same bit order as m_tdata, lowest field last
	typedef struct packed {
		logic [7:0]  alpha;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic        fill;
		logic        outline;
		logic [13:0] py;
		logic [13:0] px;
	} pixel_t;

	pixel_t     pending_pixels [$];
	logic [3:0] ring_width;

	function automatic int floor_root(int v);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = 1024;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (mid * mid <= v)
				lo = mid;
			else
				hi = mid;
		end
		return lo;
	endfunction

	function automatic pixel_t classify_pixel(logic [79:0] req, logic [3:0] ring);
		pixel_t p;
		int dx;
		int dy;
		int cx;
		int cy;
		int rad;
		int d2;
		int inner;
		int outer;
		dx = int'($signed(req[9:0]));
		dy = int'($signed(req[19:10]));
		cx = int'(req[31:20]);
		cy = int'(req[43:32]);
		rad = int'(req[51:44]);
		d2 = dx * dx + dy * dy;
		inner = rad * rad;
		outer = (rad + int'(ring)) * (rad + int'(ring));
		p.px = 14'(cx + dx);
		p.py = 14'(cy + dy);
		p.outline = (d2 >= inner) && (d2 <= outer);
		p.fill = (d2 <= inner);
		p.red = req[59:52];
		p.green = req[67:60];
		p.blue = req[75:68];
		if (!p.fill)
			p.alpha = 8'd0;
		else if (rad == 0)
			p.alpha = cogp_pkg::ALPHA_MAX;
		else
			p.alpha = 8'(255 - (255 * floor_root(d2)) / rad);
		return p;
	endfunction

	function automatic int field_differs(string name, int want, int got);
		if (want == got)
			return 0;
		$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		pixel_t got;
		int bad;
		if (!arst_n) begin
			ring_width <= cogp_pkg::THICK_RST;
			pending_pixels.delete();
			in_flight <= 0;
			mismatches <= 0;
		end else begin
			bad = 0;
			if (cfg_wen)
				ring_width <= cfg_wdata;
			if (s_tvalid && s_tready)
				pending_pixels.push_back(classify_pixel(s_tdata, ring_width));
			if (m_tvalid && m_tready) begin
				got = pixel_t'(m_tdata[61:0]);
				if (pending_pixels.size() == 0) begin
					$display("%0t: result with no request waiting, expected none got %h",
						$time, m_tdata);
					bad++;
				end else begin
					want = pending_pixels.pop_front();
					bad += field_differs("pixel_x", int'($signed(want.px)),
						int'($signed(got.px)));
					bad += field_differs("pixel_y", int'($signed(want.py)),
						int'($signed(got.py)));
					bad += field_differs("draw_outline", int'(want.outline),
						int'(got.outline));
					bad += field_differs("draw_fill", int'(want.fill), int'(got.fill));
					bad += field_differs("fill_red", int'(want.red), int'(got.red));
					bad += field_differs("fill_green", int'(want.green), int'(got.green));
					bad += field_differs("fill_blue", int'(want.blue), int'(got.blue));
					bad += field_differs("fill_alpha", int'(want.alpha), int'(got.alpha));
				end
			end
			in_flight <= pending_pixels.size();
			mismatches <= mismatches + bad;
		end
	end

endmodule

// File: sim/tb_circle_outline_gradient_pixel.sv
// Testbench top: drives pixel requests and thickness writes, and reports the verdict.
module tb_circle_outline_gradient_pixel;

	localparam int HOLD_CYCLES = 80;
	localparam int IDLE_LIMIT  = 4000;
	localparam int PHASE_ITEMS = 150;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wen;
	logic [3:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        calm;
	logic        hold_off_req;
	int          in_flight;
	int          mismatches;
	int          idle_cycles = 0;

	always #5 clk = ~clk;

	circle_outline_gradient_pixel dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	circle_pixel_monitor mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.in_flight  (in_flight),
		.mismatches (mismatches)
	);

	// rgb is {blue, green, red}
	function automatic logic [79:0] pack_req(int dx, int dy, int cx, int cy, int rad,
		logic [23:0] rgb);
		return {4'b0, rgb, 8'(rad), 12'(cy), 12'(cx), 10'(dy), 10'(dx)};
	endfunction

	function automatic logic [79:0] random_req();
		int rad;
		int span;
		if ($urandom_range(0, 3) == 0)
			return pack_req($urandom, $urandom, $urandom, $urandom, $urandom,
				24'($urandom));
		// mostly positions near the disc so fill and ring are hit often
		if ($urandom_range(0, 3) == 0)
			rad = $urandom_range(0, 8);
		else
			rad = $urandom_range(0, 255);
		span = rad + 18;
		return pack_req(int'($urandom_range(0, 2 * span)) - span,
			int'($urandom_range(0, 2 * span)) - span,
			$urandom, $urandom, rad, 24'($urandom));
	endfunction

	task automatic offer(input logic [79:0] word);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain_and_write(input logic [3:0] ring);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= ring;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// result side
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("circle_outline_gradient_pixel verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [3:0] ring;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = 4'd0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		calm = 1'b0;
		hold_off_req = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thickness of 3
		offer(pack_req(0, 0, 0, 0, 0, 24'h000000));
		offer(pack_req(1, 0, 100, 100, 0, 24'($urandom)));
		offer(pack_req(3, 0, 100, 100, 0, 24'($urandom)));
		offer(pack_req(4, 0, 100, 100, 0, 24'($urandom)));
		offer(pack_req(-512, -512, 0, 0, 255, 24'hFFFFFF));
		offer(pack_req(511, 511, 4095, 4095, 255, 24'h000000));
		offer(pack_req(255, 0, 1000, 2000, 255, 24'($urandom)));
		offer(pack_req(0, -255, 3000, 500, 255, 24'($urandom)));
		offer(pack_req(258, 0, 1000, 1000, 255, 24'($urandom)));
		offer(pack_req(259, 0, 1000, 1000, 255, 24'($urandom)));
		offer(pack_req(0, 0, 2048, 2048, 255, 24'hFFFFFF));
		offer(pack_req(3, 4, 10, 10, 10, 24'($urandom)));
		offer(pack_req(5, 5, 10, 10, 10, 24'($urandom)));
		offer(pack_req(7, 7, 10, 10, 10, 24'($urandom)));
		offer(pack_req(-7, 8, 10, 10, 10, 24'($urandom)));
		offer(pack_req(1, 1, 5, 5, 1, 24'($urandom)));
		offer(pack_req(0, 1, 5, 5, 1, 24'($urandom)));
		offer(pack_req(100, -100, 700, 800, 200, 24'($urandom)));
		offer(pack_req(-300, 400, 0, 4095, 255, 24'($urandom)));
		offer(pack_req(511, -512, 4095, 0, 128, 24'h0F55AA));
		offer(pack_req(-1, -1, 1, 1, 2, 24'($urandom)));
		offer(pack_req(0, 0, 2048, 0, 1, 24'($urandom)));

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: ring = 4'd15;
				1: ring = 4'd0;
				2: ring = 4'd7;
				3: ring = 4'd1;
				4: ring = 4'd15;
				5: ring = 4'd12;
				default: ring = 4'd0;
			endcase
			drain_and_write(ring);
			if (ph == 1)
				hold_off_req = 1'b1;
			if (ph == 6)
				calm = 1'b1;
			repeat (PHASE_ITEMS) offer(random_req());
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("circle_outline_gradient_pixel verification clean");
		else
			$display("circle_outline_gradient_pixel verification failed");
		$finish;
	end

endmodule
